FILE: src/ldc_pkg.sv
// Package with the beat types, state type and codes of the locomotive decoder command handler.
package ldc_pkg;

  localparam int unsigned FuncCount = 32;
  localparam int unsigned IntervalWidth = 16;
  localparam logic [IntervalWidth-1:0] IntervalReset = 16'd100;
  localparam logic [6:0] StepMask = 7'h7F;

  localparam logic CMD_SPEED = 1'b0;
  localparam logic CMD_FUNCTION = 1'b1;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_SET = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;
  localparam logic [1:0] ACT_KEEP = 2'd3;

  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_HELD = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic        command;
    logic [13:0] loco_address;
    logic [7:0]  speed_code;
    logic [5:0]  function_number;
    logic [1:0]  function_action;
    logic [31:0] now_ms;
  } ldc_in_t;

  typedef struct packed {
    logic [13:0] report_address;
    logic [6:0]  forward_duty;
    logic [6:0]  backward_duty;
    logic        front_light;
    logic        rear_light;
    logic [7:0]  speed_report;
    logic [4:0]  group_f0_f4;
    logic [7:0]  group_f5_f12;
    logic [7:0]  group_f13_f20;
    logic [7:0]  group_f21_f28;
    logic [2:0]  group_f29_f31;
    logic [1:0]  status;
  } ldc_out_t;

  typedef struct packed {
    logic [FuncCount-1:0] function_flags;
    logic [7:0]           speed_byte;
    logic [31:0]          last_apply_time;
    logic [6:0]           forward_drive;
    logic [6:0]           backward_drive;
    logic                 front_lamp;
    logic                 rear_lamp;
  } ldc_state_t;

endpackage

FILE: src/loco_decoder_command_handler_unit.sv
// Top level of the locomotive decoder command handler: input register, state and report register.
//
//   Channel | Direction | Handshake              | Beat
//   in_     | input     | in_valid / in_stall    | ldc_in_t command
//   out_    | output    | out_valid / out_stall  | ldc_out_t report
//   cfg_    | input     | cfg_valid / cfg_ready  | 16-bit minimum speed interval
//
// A command beat is registered in the input register, executed combinationally from it, and its
// report is then registered; one command is taken every cycle while the report is not stalled.
// The decoder state updates at the same edge that loads the report register.
// Reset clears all function flags, drives and lamps and sets the interval to 100 ms.
// A stalled report holds the input register, which then raises in_stall.
module loco_decoder_command_handler_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ldc_pkg::ldc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ldc_pkg::ldc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import ldc_pkg::*;

  logic                     in_valid_r;
  ldc_in_t                  in_data_r;
  logic                     out_valid_r;
  ldc_out_t                 out_data_r;
  ldc_state_t               state_r;
  ldc_state_t               state_nxt;
  ldc_out_t                 result_nxt;
  logic [IntervalWidth-1:0] interval_r;
  logic                     advance;

  assign advance = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign cfg_ready = 1'b1;

  ldc_exec u_exec (
    .item     (in_data_r),
    .cur      (state_r),
    .interval (interval_r),
    .nxt      (state_nxt),
    .result   (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
      interval_r <= IntervalReset;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result_nxt;
    end
  end

endmodule

FILE: src/ldc_exec.sv
// Combinational command execution: next decoder state and the report for one command.
module ldc_exec (
  input  ldc_pkg::ldc_in_t    item,
  input  ldc_pkg::ldc_state_t cur,
  input  logic [15:0]         interval,
  output ldc_pkg::ldc_state_t nxt,
  output ldc_pkg::ldc_out_t   result
);
  import ldc_pkg::*;

  logic [6:0]           step;
  logic [6:0]           duty;
  logic [31:0]          due_time;
  logic                 elapsed;
  logic                 recompute;
  logic [FuncCount-1:0] fbit;
  logic [FuncCount-1:0] flags;
  logic [1:0]           status;
  logic                 fwd;

  always_comb begin
    step = item.speed_code[6:0] & StepMask;
    duty = (step == 7'd0) ? 7'd0 : step - 7'd1;
    due_time = cur.last_apply_time + {16'd0, interval};
    elapsed = due_time < item.now_ms;
    fbit = {{(FuncCount-1){1'b0}}, 1'b1} << item.function_number[4:0];
    nxt = cur;
    status = ST_APPLIED;
    recompute = 1'b1;
    flags = cur.function_flags;

    if (item.command == CMD_SPEED) begin
      nxt.speed_byte = item.speed_code;
      if (step <= 7'd1 || elapsed) begin
        if (step > 7'd1) begin
          nxt.last_apply_time = item.now_ms;
        end
        if (step != 7'd0 && item.speed_code[7]) begin
          nxt.forward_drive = duty;
          nxt.backward_drive = 7'd0;
        end else begin
          nxt.forward_drive = 7'd0;
          nxt.backward_drive = duty;
        end
      end else begin
        status = ST_HELD;
        recompute = 1'b0;
      end
    end else begin
      if (item.function_number[5]) begin
        status = ST_RANGE;
      end else begin
        case (item.function_action)
          ACT_CLEAR:  flags = cur.function_flags & ~fbit;
          ACT_SET:    flags = cur.function_flags | fbit;
          ACT_TOGGLE: flags = cur.function_flags ^ fbit;
          default:    flags = cur.function_flags;
        endcase
      end
      nxt.function_flags = flags;
    end

    fwd = nxt.speed_byte[7];
    if (recompute) begin
      nxt.front_lamp = 1'b0;
      nxt.rear_lamp = 1'b0;
      if (flags[0]) begin
        if (!flags[1]) begin
          nxt.front_lamp = 1'b1;
          nxt.rear_lamp = 1'b1;
        end else if (fwd) begin
          nxt.front_lamp = !flags[2];
        end else begin
          nxt.rear_lamp = !flags[3];
        end
      end
    end

    result.report_address = item.loco_address;
    result.forward_duty = nxt.forward_drive;
    result.backward_duty = nxt.backward_drive;
    result.front_light = nxt.front_lamp;
    result.rear_light = nxt.rear_lamp;
    result.speed_report = nxt.speed_byte;
    result.group_f0_f4 = {nxt.function_flags[0], nxt.function_flags[4:1]};
    result.group_f5_f12 = nxt.function_flags[12:5];
    result.group_f13_f20 = nxt.function_flags[20:13];
    result.group_f21_f28 = nxt.function_flags[28:21];
    result.group_f29_f31 = nxt.function_flags[31:29];
    result.status = status;
  end

endmodule

FILE: src/ldc_checker.sv
// Port checker for the locomotive decoder command handler and its bind to the top level.
module ldc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ldc_pkg::ldc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input ldc_pkg::ldc_out_t out_data
);
  import ldc_pkg::*;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("Stalled command beat changed or dropped.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled report beat changed or dropped.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.forward_duty == 7'd0 || out_data.backward_duty == 7'd0))
    else $error("Both motor outputs driven at once.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.group_f0_f4[4] |-> !out_data.front_light && !out_data.rear_light)
    else $error("Lamp lit while F0 is off.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_APPLIED || out_data.status == ST_HELD
                   || out_data.status == ST_RANGE))
    else $error("Report carries an unknown status.");

endmodule

bind loco_decoder_command_handler_unit ldc_checker u_ldc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
